>>> rtl/core/pcpt_pkg.sv
// Package with shared types, constants and register indexes for the pin change and timer block.
package pcpt_pkg;

    localparam int PIN_BITS     = 8;
    localparam int TIMER_SLOTS  = 4;
    localparam int BUTTONS      = 8;
    localparam int TIMERS_DEF   = 4;
    localparam int EVT_BITS     = PIN_BITS + TIMER_SLOTS;
    localparam int SEL_W        = $clog2(EVT_BITS);
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int WATCH_MAX    = (BUTTONS < PIN_BITS) ? BUTTONS : PIN_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE  = 3'd0,
        CFG_PERIOD0 = 3'd1,
        CFG_PERIOD1 = 3'd2,
        CFG_PERIOD2 = 3'd3,
        CFG_PERIOD3 = 3'd4
    } t_cfg_idx;

    localparam logic KIND_BUTTON = 1'b0;
    localparam logic KIND_TIMER  = 1'b1;

    typedef struct packed {
        logic [TIMER_SLOTS-1:0] tmr_mask;
        logic [PIN_BITS-1:0]    btn_mask;
        logic [PIN_BITS-1:0]    btn_lvl;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> rtl/core/pin_change_and_periodic_timer_events.sv
// Top level of the pin change and periodic timer event block.
// Events of a poll go into the job queue, then into back end registers, before they show.
// The back end emits one event per cycle while the sink is ready, one for each event of a poll.
// The front takes a poll per cycle until the two-entry job queue is full.
// Reset (synchronous, active low) clears registers, queue and baseline; the first poll
// after reset loads the baseline levels and timer starts and emits nothing.
module pin_change_and_periodic_timer_events
    import pcpt_pkg::*;
#(
    parameter int TIMERS = TIMERS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [47:0]           i_s_tdata,  // now_ms[31:0], pin_levels[39:32], restart_mask[43:40]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,  // channel[2:0], level[3]
    output logic                  o_m_tuser,  // event_kind[0]
    output logic                  o_m_tlast
);

    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;
    logic    push;
    logic    pop;
    logic [2:0] channel;
    logic    level;

    pcpt_front #(
        .TIMERS(TIMERS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_s_tvalid),
        .i_now_ms       (i_s_tdata[31:0]),
        .i_pin_levels   (i_s_tdata[39:32]),
        .i_restart_mask (i_s_tdata[43:40]),
        .i_q_stat       (q_stat),
        .o_ready        (o_s_tready),
        .o_push         (push),
        .o_job          (push_job)
    );

    pcpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    pcpt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (head_job),
        .i_q_stat  (q_stat),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_kind    (o_m_tuser),
        .o_channel (channel),
        .o_level   (level),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {4'b0000, level, channel};

    a_q_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("job queue reports full and empty");

    a_timer_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_TIMER) |->
        (o_m_tdata[3] == 1'b0 && 32'(o_m_tdata[2:0]) < 32'(TIMERS)))
        else $error("timer event with bad level or channel");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast && q_stat.empty) |=> !o_m_tvalid)
        else $error("event shown after last of drained queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("job pushed into full queue");

endmodule

>>> rtl/core/pcpt_front.sv
// Front end: accept polls, hold configuration and state, classify events into a job.
module pcpt_front
    import pcpt_pkg::*;
#(
    parameter int TIMERS = TIMERS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic [31:0]           i_now_ms,
    input  logic [PIN_BITS-1:0]   i_pin_levels,
    input  logic [3:0]            i_restart_mask,
    input  t_q_stat               i_q_stat,
    output logic                  o_ready,
    output logic                  o_push,
    output t_job                  o_job
);

    logic [3:0]          r_active;
    logic [31:0]         r_period [TIMERS];
    logic [31:0]         r_start  [TIMERS];
    logic [31:0]         n_start  [TIMERS];
    logic [PIN_BITS-1:0] r_lvl;
    logic [PIN_BITS-1:0] n_lvl;
    logic                r_primed;
    logic [3:0]          watched;
    logic [PIN_BITS-1:0] btn_mask;
    logic [TIMER_SLOTS-1:0] tmr_mask;
    logic [31:0]         start_eff;
    logic                accept;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        watched = (r_active > 4'(WATCH_MAX)) ? 4'(WATCH_MAX) : r_active;
        for (int i = 0; i < PIN_BITS; i++) begin
            btn_mask[i] = (4'(i) < watched) && (i_pin_levels[i] != r_lvl[i]);
            n_lvl[i]    = btn_mask[i] ? i_pin_levels[i] : r_lvl[i];
        end
        tmr_mask  = '0;
        start_eff = '0;
        for (int t = 0; t < TIMERS; t++) begin
            start_eff   = i_restart_mask[t] ? i_now_ms : r_start[t];
            tmr_mask[t] = (r_period[t] != 32'd0) && ((i_now_ms - start_eff) >= r_period[t]);
            n_start[t]  = (i_restart_mask[t] || tmr_mask[t]) ? i_now_ms : r_start[t];
        end
    end

    assign o_job.btn_mask = btn_mask;
    assign o_job.btn_lvl  = i_pin_levels;
    assign o_job.tmr_mask = tmr_mask;
    assign o_push = accept && r_primed && ((|btn_mask) || (|tmr_mask));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_primed <= 1'b0;
            r_lvl    <= '0;
            for (int t = 0; t < TIMERS; t++) begin
                r_period[t] <= '0;
                r_start[t]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACTIVE: r_active <= i_cfg_data[3:0];
                    default: begin
                        for (int t = 0; t < TIMERS; t++) begin
                            if (i_cfg_idx == CFG_IDX_W'(int'(CFG_PERIOD0) + t)) begin
                                r_period[t] <= i_cfg_data;
                            end
                        end
                    end
                endcase
            end
            if (accept) begin
                r_primed <= 1'b1;
                if (!r_primed) begin
                    r_lvl <= i_pin_levels;
                    for (int t = 0; t < TIMERS; t++) begin
                        r_start[t] <= i_now_ms;
                    end
                end else begin
                    r_lvl <= n_lvl;
                    for (int t = 0; t < TIMERS; t++) begin
                        r_start[t] <= n_start[t];
                    end
                end
            end
        end
    end

endmodule

>>> rtl/core/pcpt_queue.sv
// Short job queue between the front and back ends.
module pcpt_queue
    import pcpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_cnt == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/core/pcpt_back.sv
// Back end: walk a job's event mask and emit one event per transaction.
module pcpt_back
    import pcpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_kind,
    output logic [2:0] o_channel,
    output logic       o_level,
    output logic       o_last
);

    logic                r_busy;
    logic [EVT_BITS-1:0] r_mask;
    logic [PIN_BITS-1:0] r_lvl;
    logic [EVT_BITS-1:0] rest;
    logic [SEL_W-1:0]    sel;
    logic                hs;

    always_comb begin
        sel = '0;
        for (int j = EVT_BITS - 1; j >= 0; j--) begin
            if (r_mask[j]) begin
                sel = SEL_W'(j);
            end
        end
    end

    assign rest      = r_mask & (r_mask - 1'b1);
    assign o_valid   = r_busy;
    assign o_last    = (rest == '0);
    assign o_kind    = (sel >= SEL_W'(PIN_BITS)) ? KIND_TIMER : KIND_BUTTON;
    assign o_channel = (o_kind == KIND_TIMER) ? 3'(sel - SEL_W'(PIN_BITS)) : sel[2:0];
    assign o_level   = (o_kind == KIND_TIMER) ? 1'b0 : r_lvl[sel[2:0]];
    assign hs        = r_busy && i_ready;
    assign o_pop     = !i_q_stat.empty && (!r_busy || (hs && o_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mask <= '0;
            r_lvl  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_mask <= {i_job.tmr_mask, i_job.btn_mask};
            r_lvl  <= i_job.btn_lvl;
        end else if (hs) begin
            r_mask <= rest;
            r_busy <= !o_last;
        end
    end

endmodule
